[rtl/wsi_pkg.sv]
`timescale 1ns / 1ps
package wsi_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int HIST_DEPTH     = 7;
  localparam int CNT_W          = 3;
  localparam int MIN_NEWEST     = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned PI_Q29  = 64'd1686629713;
  localparam longint          W_A0    = 64'sd450971566;
  localparam longint          W_A1    = 64'sd536870912;
  localparam longint          W_A2    = 64'sd85899346;

  typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] hist_t;

  typedef struct packed {
    hist_t            hist;
    logic [CNT_W-1:0] newest;
    logic             fin;
    logic             err;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

  // shift-subtract division, used only while building the coefficient table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 0;
    quo = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned umod(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) rem = rem - den;
    end
    return rem;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    logic neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? longint'(-a) : longint'(a);
    ub  = (b < 0) ? longint'(-b) : longint'(b);
    r   = (ua * ub + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // cos(pi*num/den) in q30, folded taylor series
  function automatic longint cos_pi(longint unsigned num, longint unsigned den);
    logic neg;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    neg = 1'b0;
    a   = umod(num, 2 * den);
    if (a > den) a = 2 * den - a;
    if (2 * a == den) return 0;
    if (2 * a > den) begin
      a   = den - a;
      neg = 1'b1;
    end
    x    = udiv(PI_Q30 * a + (den >> 1), den);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int k = 1; k <= 14; k++) begin
      term = udiv((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  // one tap of the sinc * blackman filter, rounded to f fraction bits
  function automatic longint coeff_calc(int n, int l, int f);
    longint unsigned m;
    longint unsigned dd;
    longint unsigned sm;
    longint unsigned dv;
    longint unsigned q;
    longint unsigned mag;
    longint s;
    longint sinc;
    longint w;
    longint hw;
    int shift;
    m = (n >= 3 * l) ? longint'(n - 3 * l) : longint'(3 * l - n);
    if (m == 0) begin
      sinc = longint'(Q30_ONE);
    end else begin
      dd   = (2 * m > longint'(l)) ? 2 * m - longint'(l) : longint'(l) - 2 * m;
      s    = cos_pi(dd, longint'(2 * l));
      sm   = (s < 0) ? longint'(-s) : longint'(s);
      dv   = PI_Q29 * m;
      q    = udiv(((sm * longint'(l)) << 29) + (dv >> 1), dv);
      sinc = (s < 0) ? -longint'(q) : longint'(q);
    end
    w  = W_A0 - q30_mul(W_A1, cos_pi(longint'(n), longint'(3 * l)))
       + q30_mul(W_A2, cos_pi(longint'(2 * n), longint'(3 * l)));
    hw = q30_mul(sinc, w);
    mag   = (hw < 0) ? longint'(-hw) : longint'(hw);
    shift = 30 - f;
    mag   = (mag + (64'd1 << (shift - 1))) >> shift;
    return (hw < 0) ? -longint'(mag) : longint'(mag);
  endfunction

endpackage

[rtl/wsi_front.sv]
`timescale 1ns / 1ps
module wsi_front import wsi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  input  logic                       q_full,
  output logic                       push,
  output job_t                       push_job
);

  hist_t            hist;
  hist_t            hist_next;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] newest;
  logic             accept;
  logic             short_seq;

  always_comb begin
    hist_next = {hist[HIST_DEPTH-2:0], sample};
    seen_next = (seen == CNT_W'(HIST_DEPTH)) ? seen : seen + 1'b1;
    newest    = seen_next - 1'b1;
    short_seq = newest < CNT_W'(MIN_NEWEST);
    in_ready  = !q_full;
    accept    = in_valid && in_ready;
    push      = accept && (last_sample || !short_seq);
    push_job.hist   = hist_next;
    push_job.newest = newest;
    push_job.fin    = last_sample;
    push_job.err    = last_sample && short_seq;
  end

  // history is payload, never cleared
  always_ff @(posedge clk) begin
    if (accept) hist <= hist_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= last_sample ? '0 : seen_next;
    end
  end

endmodule

[rtl/wsi_queue.sv]
`timescale 1ns / 1ps
module wsi_queue import wsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

[rtl/wsi_back.sv]
`timescale 1ns / 1ps
module wsi_back import wsi_pkg::*; #(
  parameter int UPSAMPLE_FACTOR = 4,
  parameter int COEFF_FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  job_t                       job_in,
  output logic                       job_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] value,
  output logic                       last_output,
  output logic                       saturated,
  output logic                       too_short
);

  localparam int L      = UPSAMPLE_FACTOR;
  localparam int NTAPS  = 6 * L + 1;
  localparam int TAP_W  = $clog2(NTAPS);
  localparam int CW     = COEFF_FRAC_BITS + 2;
  localparam int SW     = CW + 2;
  localparam int IW     = $clog2(20 * L) + 2;
  localparam int PW     = $clog2(6 * L + 1);
  localparam int PROD_W = SAMPLE_W + SW;
  localparam int AW     = COEFF_FRAC_BITS + 23;

  localparam logic signed [IW-1:0] L_S      = IW'(L);
  localparam logic signed [IW-1:0] CENTER_S = IW'(3 * L);
  localparam logic signed [IW-1:0] LAST_TAP = IW'(6 * L);
  localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] MAX_V    = AW'(32767);
  localparam logic signed [AW-1:0] MIN_V    = -MAX_V - AW'(1);

  logic signed [CW-1:0] coef_tab [NTAPS];

  for (genvar gt = 0; gt < NTAPS; gt++) begin : g_coef
    localparam longint CV = coeff_calc(gt, L, COEFF_FRAC_BITS);
    assign coef_tab[gt] = CW'(CV);
  end

  back_state_t          state;
  back_state_t          state_next;
  logic                 issue;
  logic                 emit;
  logic [CNT_W-1:0]     d;
  logic                 drain;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        hi;
  logic [PW-1:0]        lo_v;
  logic [PW-1:0]        hi_v;
  hist_t                job_hist;
  logic [CNT_W-1:0]     job_k;
  logic                 job_fin;
  logic                 job_err;
  logic signed [IW-1:0] end_pos;
  logic                 at_hi;

  // coefficient gather
  logic signed [IW-1:0] s_cnt;
  logic signed [IW-1:0] s_pl;
  logic signed [IW-1:0] i_s;
  logic signed [IW-1:0] t0;
  logic signed [IW-1:0] t1;
  logic signed [IW-1:0] t2;
  logic signed [SW-1:0] c0;
  logic signed [SW-1:0] cm;
  logic signed [SW-1:0] ce;
  logic signed [SW-1:0] csum;
  logic                 in_hist;

  // mac pipeline
  logic                       v1;
  logic signed [SW-1:0]       c1;
  logic signed [SAMPLE_W-1:0] s1;
  logic                       v2;
  logic signed [PROD_W-1:0]   p2;
  logic signed [AW-1:0]       acc;
  logic signed [AW-1:0]       rnd_sum;
  logic signed [AW-1:0]       qv;

  always_comb begin
    lo_v = (job_in.newest >= CNT_W'(4)) ? PW'((int'(job_in.newest) - 4) * L + 1) : '0;
    hi_v = job_in.fin ? PW'(int'(job_in.newest) * L) : PW'((int'(job_in.newest) - 3) * L);
    at_hi = pos == hi;
  end

  always_comb begin
    in_hist = d <= job_k;
    s_cnt   = IW'(job_k) - IW'(d);
    s_pl    = s_cnt * L_S;
    i_s     = IW'(pos);
    t0      = s_pl - i_s + CENTER_S;
    t1      = -s_pl - i_s + CENTER_S;
    t2      = end_pos - s_pl - i_s + CENTER_S;
    c0 = '0;
    cm = '0;
    ce = '0;
    if (in_hist && t0 >= 0 && t0 <= LAST_TAP) c0 = SW'(coef_tab[t0[TAP_W-1:0]]);
    if (in_hist && s_pl > 0 && t1 >= 0 && t1 <= LAST_TAP) cm = SW'(coef_tab[t1[TAP_W-1:0]]);
    if (in_hist && job_fin && t2 >= 0 && t2 <= LAST_TAP) ce = SW'(coef_tab[t2[TAP_W-1:0]]);
    csum = c0 + cm + ce;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = job_in.err ? BK_EMIT : BK_RUN;
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        if (d == CNT_W'(HIST_DEPTH - 1)) state_next = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (drain) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = (job_err || at_hi) ? BK_IDLE : BK_RUN;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      d         <= '0;
      drain     <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (job_pop || emit) d <= '0;
      else if (issue) d <= d + 1'b1;
      drain <= (state == BK_DRAIN) ? !drain : 1'b0;
      v1    <= issue;
      v2    <= v1;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_hist <= job_in.hist;
      job_k    <= job_in.newest;
      job_fin  <= job_in.fin;
      job_err  <= job_in.err;
      pos      <= lo_v;
      hi       <= hi_v;
      end_pos  <= IW'((2 * int'(job_in.newest) + 1) * L);
    end else if (emit && !at_hi) begin
      pos <= pos + 1'b1;
    end
    c1 <= csum;
    s1 <= in_hist ? job_hist[d[CNT_W-1:0]] : '0;
    p2 <= s1 * c1;
    if (job_pop || emit) acc <= '0;
    else if (v2) acc <= acc + {{(AW - PROD_W){p2[PROD_W-1]}}, p2};
  end

  always_comb begin
    rnd_sum = acc + RND_HALF;
    qv      = rnd_sum >>> COEFF_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (job_err) begin
        value       <= '0;
        last_output <= 1'b1;
        saturated   <= 1'b0;
        too_short   <= 1'b1;
      end else begin
        if (qv > MAX_V) value <= MAX_V[SAMPLE_W-1:0];
        else if (qv < MIN_V) value <= MIN_V[SAMPLE_W-1:0];
        else value <= qv[SAMPLE_W-1:0];
        saturated   <= (qv > MAX_V) || (qv < MIN_V);
        last_output <= job_fin && at_hi;
        too_short   <= 1'b0;
      end
    end
  end

endmodule

[rtl/windowed_sinc_interpolator_top.sv]
`timescale 1ns / 1ps
// path: an accepted item goes through the queue, then the back runs one mac per history tap,
//   drains the pipeline and rounds the result; every mac uses the single shared multiplier,
//   and the back takes no new job until the last output of the current one is emitted
// reset: rst is synchronous, active high; clears sample count, queue and sequencer,
//   sample history is left undefined until written
module windowed_sinc_interpolator_top import wsi_pkg::*; #(
  parameter int UPSAMPLE_FACTOR = 4,
  parameter int COEFF_FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] value,
  output logic                       last_output,
  output logic                       saturated,
  output logic                       too_short
);

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic job_valid;
  logic job_pop;
  job_t job;

  // front keeps the seven newest samples and decides what each item releases
  wsi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .last_sample (last_sample),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // short job queue with a snapshot of the history, lets both sides stall apart
  wsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (job_valid),
    .pop       (job_pop),
    .pop_job   (job)
  );

  // back walks the released positions, one mac per history tap, into the output register
  wsi_back #(
    .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_in      (job),
    .job_pop     (job_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .last_output (last_output),
    .saturated   (saturated),
    .too_short   (too_short)
  );

  // queue is never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job queue overflow");

  // error result is a bare marker
  a_short_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> last_output && value == '0 && !saturated)
    else $error("malformed short sequence result");

  // a clipped result sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (value == 16'sh7fff || value == 16'sh8000))
    else $error("saturated flag without clipped value");

endmodule
